### hdl/cfi_pkg.sv
// Shared types and codes for the circular FIFO with interleave.
// Used by cfi_ctrl, cfi_dp and circular_fifo_with_interleave_core; depends on nothing.
`default_nettype none

package cfi_pkg;

   localparam int WORD_W   = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // request operation codes
   localparam logic [ACTION_W-1:0] ACT_ENQUEUE    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQUEUE    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK       = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_INTERLEAVE = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STS_ODD_COUNT = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic enq;         // write value at tail, count up
      logic deq;         // read head, advance head, count down
      logic peek;        // read head
      logic walk_start;  // load pair index and half count
      logic copy_rd;     // read slot head+idx
      logic copy_wr;     // write scratch[idx] from slot read data
      logic merge_rd;    // read slot head+half+idx and scratch[idx]
      logic merge_w0;    // write slot head+2idx from scratch read data
      logic merge_w1;    // write slot head+2idx+1 from slot read data
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
      logic                     is_full;
      logic                     is_odd;
      logic                     idx_last;
   } stat_type;

endpackage

`default_nettype wire

### hdl/circular_fifo_with_interleave_core.sv
// Top level of the circular FIFO with interleave: controller plus datapath.
// Depends on cfi_pkg, cfi_ctrl and cfi_dp.
//
// A ring-buffer FIFO of DEPTH signed 32-bit words. Each request word carries one
// operation: enqueue, dequeue, peek or interleave halves; each request yields exactly
// one response word with data, status, the count after the operation and the empty and
// full flags. For enqueue, dequeue and peek the request is accepted, the slot memory is
// read or written at that edge, and the response shows up in the output register on
// the next cycle. A new request is taken in the same cycle the previous response is
// taken, so these three run at one word per cycle. Interleave
// with an even count n reorders the stored words in place through a scratch memory
// and holds req_stall high after acceptance until the reorder is done: each word of
// the first half is read and copied out, then each pair is read and written back as
// two slots through the single write port of the slot memory. Its response (data 0)
// is presented at once and may be taken while the reorder runs. Interleave with an
// odd count is refused with status 3; enqueue when full reports status 1, dequeue
// or peek when empty reports status 2 with data -1. The slot and scratch memories
// are not cleared by reset; only written entries are ever read.
`default_nettype none

module circular_fifo_with_interleave_core #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfi_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfi_pkg::rsp_type rsp_word
);
   import cfi_pkg::*;

   cmd_type  cmd;   // per-cycle datapath commands
   stat_type stat;  // count, flags, read data and walk progress

   // decode requests, sequence the interleave walk, hold the response
   cfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .stat      (stat)
   );

   // storage, ring pointers and the pair index of the walk
   cfi_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .value (req_word.value),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

`default_nettype wire

### hdl/cfi_ctrl.sv
// Controller of the circular FIFO: request decode, interleave sequencer, result register.
// Depends on cfi_pkg; drives cfi_dp through cmd_type and reads stat_type.
`default_nettype none

module cfi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cfi_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cfi_pkg::rsp_type rsp_word,
   output cfi_pkg::cmd_type cmd,
   input  cfi_pkg::stat_type stat
);
   import cfi_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_MERGE_RD,
      ST_MERGE_W0,
      ST_MERGE_W1
   } state_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_NEG_ONE,
      SEL_MEM
   } sel_type;

   state_type           state_ff, state_in;
   sel_type             sel_ff, sel_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      status_in = status_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept    = req_valid && !req_stall;
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = STS_OK;
               sel_in    = SEL_ZERO;
               unique case (req_word.action)
                  ACT_ENQUEUE: begin
                     if (stat.is_full) status_in = STS_OVERFLOW;
                     else              cmd.enq = 1'b1;
                  end
                  ACT_DEQUEUE: begin
                     if (stat.is_empty) begin
                        status_in = STS_UNDERFLOW;
                        sel_in    = SEL_NEG_ONE;
                     end else begin
                        cmd.deq = 1'b1;
                        sel_in  = SEL_MEM;
                     end
                  end
                  ACT_PEEK: begin
                     if (stat.is_empty) begin
                        status_in = STS_UNDERFLOW;
                        sel_in    = SEL_NEG_ONE;
                     end else begin
                        cmd.peek = 1'b1;
                        sel_in   = SEL_MEM;
                     end
                  end
                  ACT_INTERLEAVE: begin
                     if (stat.is_odd) begin
                        status_in = STS_ODD_COUNT;
                     end else if (!stat.is_empty) begin
                        cmd.walk_start = 1'b1;
                        state_in       = ST_COPY_RD;
                     end
                  end
                  default: status_in = STS_OK;
               endcase
            end
         end
         ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            state_in    = stat.idx_last ? ST_MERGE_RD : ST_COPY_RD;
         end
         ST_MERGE_RD: begin
            cmd.merge_rd = 1'b1;
            state_in     = ST_MERGE_W0;
         end
         ST_MERGE_W0: begin
            cmd.merge_w0 = 1'b1;
            state_in     = ST_MERGE_W1;
         end
         ST_MERGE_W1: begin
            cmd.merge_w1 = 1'b1;
            state_in     = stat.idx_last ? ST_IDLE : ST_MERGE_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= SEL_ZERO;
         status_ff    <= STS_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
         status_ff    <= status_in;
      end
   end

   // count and flags are live: nothing changes them while a result waits
   always_comb begin
      rsp_valid         = rsp_valid_ff;
      rsp_word.status   = status_ff;
      rsp_word.count    = stat.count;
      rsp_word.is_empty = stat.is_empty;
      rsp_word.is_full  = stat.is_full;
      case (sel_ff)
         SEL_MEM:     rsp_word.data = stat.data;
         SEL_NEG_ONE: rsp_word.data = '1;
         default:     rsp_word.data = '0;
      endcase
   end

endmodule

`default_nettype wire

### hdl/cfi_dp.sv
// Datapath of the circular FIFO: slot and scratch memories, head, count and pair index.
// Depends on cfi_pkg; commanded by cfi_ctrl.
`default_nettype none

module cfi_dp #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [cfi_pkg::WORD_W-1:0] value,
   input  cfi_pkg::cmd_type                  cmd,
   output cfi_pkg::stat_type                 stat
);
   import cfi_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int HALF = DEPTH / 2;
   localparam int SW   = (HALF > 1) ? $clog2(HALF) : 1;

   logic [WORD_W-1:0] slots_mem   [DEPTH];
   logic [WORD_W-1:0] scratch_mem [HALF];
   logic [WORD_W-1:0] slot_rd_ff;
   logic [WORD_W-1:0] scr_rd_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] half_ff, half_in;
   logic [CW-1:0] count_ff, count_in;

   logic [AW-1:0]     pair_lo_off, pair_hi_off;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              rd_en, wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [SW-1:0]     scr_idx;
   logic              idx_last;
   logic [31:0]       count_wide;

   // ring add: both operands below DEPTH, one compare and subtract
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (AW + 1)'(DEPTH)) sum = sum - (AW + 1)'(DEPTH);
      return sum[AW-1:0];
   endfunction

   always_comb begin
      pair_lo_off = AW'({idx_ff, 1'b0});
      pair_hi_off = pair_lo_off + AW'(1);
      scr_idx     = idx_ff[SW-1:0];
      idx_last    = (idx_ff == half_ff - AW'(1));

      rd_en   = cmd.deq || cmd.peek || cmd.copy_rd || cmd.merge_rd;
      rd_addr = head_ff;
      if (cmd.copy_rd)  rd_addr = wrap_add(head_ff, idx_ff);
      if (cmd.merge_rd) rd_addr = wrap_add(head_ff, half_ff + idx_ff);

      wr_en   = cmd.enq || cmd.merge_w0 || cmd.merge_w1;
      wr_addr = wrap_add(head_ff, AW'(count_ff));
      wr_data = value;
      if (cmd.merge_w0) begin
         wr_addr = wrap_add(head_ff, pair_lo_off);
         wr_data = scr_rd_ff;
      end
      if (cmd.merge_w1) begin
         wr_addr = wrap_add(head_ff, pair_hi_off);
         wr_data = slot_rd_ff;
      end

      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      half_in  = half_ff;
      if (cmd.enq) count_in = count_ff + CW'(1);
      if (cmd.deq) begin
         count_in = count_ff - CW'(1);
         head_in  = wrap_add(head_ff, AW'(1));
      end
      if (cmd.walk_start) begin
         idx_in  = '0;
         half_in = AW'(count_ff >> 1);
      end
      if (cmd.copy_wr)  idx_in = idx_last ? '0 : idx_ff + AW'(1);
      if (cmd.merge_w1) idx_in = idx_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (wr_en)        slots_mem[wr_addr]   <= wr_data;
      if (rd_en)        slot_rd_ff           <= slots_mem[rd_addr];
      if (cmd.copy_wr)  scratch_mem[scr_idx] <= slot_rd_ff;
      if (cmd.merge_rd) scr_rd_ff            <= scratch_mem[scr_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         half_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         half_ff  <= half_in;
      end
   end

   always_comb begin
      count_wide    = 32'(count_ff);
      stat.data     = slot_rd_ff;
      stat.count    = count_wide[COUNT_W-1:0];
      stat.is_empty = (count_ff == '0);
      stat.is_full  = (count_ff == CW'(DEPTH));
      stat.is_odd   = count_ff[0];
      stat.idx_last = idx_last;
   end

endmodule

`default_nettype wire
